// File: rtl/vtg_pkg.sv
package vtg_pkg;

	// item codes
	localparam logic [1:0] CMD_SAMPLE = 2'd0;
	localparam logic [1:0] CMD_OPEN   = 2'd1;
	localparam logic [1:0] CMD_CLOSE  = 2'd2;
	localparam logic [1:0] CMD_BAD    = 2'd3;

	localparam logic [2:0] EV_NONE        = 3'd0;
	localparam logic [2:0] EV_OPENED      = 3'd1;
	localparam logic [2:0] EV_CLOSED_CMD  = 3'd2;
	localparam logic [2:0] EV_CLOSED_TRIP = 3'd3;
	localparam logic [2:0] EV_REJECTED    = 3'd4;

	// degrees = floor(raw * 355 / 1040) = floor(raw * 71 / 208),
	// exact for raw < 1024 as (raw * 89482) >> 18
	localparam logic [16:0] SCALE_MUL   = 17'd89482;
	localparam int          SCALE_SHIFT = 18;

	localparam logic [8:0] THRESH_RESET = 9'd10;

	// window length is at most 32: remainders fit in 5 bits, counts in 6
	localparam int REM_W = 5;
	localparam int CNT_W = 6;
	localparam int QUEUE_DEPTH = 4;

	typedef struct packed {
		logic [1:0] cmd;
		logic [9:0] sample;
	} in_item_t;

	typedef struct packed {
		logic       valve_open;
		logic [2:0] event_res;
		logic [8:0] sample_temp;
		logic       average_valid;
		logic [8:0] average_temp;
		logic       average_is_baseline;
	} out_item_t;

	// classified item handed from front to back; temp = tq * WINDOW + tr
	typedef struct packed {
		logic [1:0]       cmd;
		logic [8:0]       temp;
		logic [8:0]       tq;
		logic [REM_W-1:0] tr;
	} work_item_t;

endpackage

// File: rtl/valve_temperature_guard.sv
// channel   direction  payload      handshake
// in        input      in_item_t    in_valid / in_ready
// out       output     out_item_t   out_valid / out_ready
// cfg       input      cfg_data     cfg_we, no wait
//
// One item per cycle sustained while the output is not stalled; each result passes
// through two front stages, the queue and the output register.
// Front scales the sample and splits it by the window length; back updates
// valve and window state once per beat from the queue head.
// Reset clears valid flags, queue pointers and valve state; threshold returns to 10 degrees.
// A stalled output fills the queue, then the front stages, then drops in_ready.
module valve_temperature_guard
	import vtg_pkg::*;
#(
	parameter int WINDOW = 20
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  in_item_t   in_item,
	output logic       out_valid,
	input  logic       out_ready,
	output out_item_t  out_item,
	input  logic       cfg_we,
	input  logic [8:0] cfg_data
);

	logic       push_valid, push_ready;
	work_item_t push_item;
	logic       head_valid, pop;
	work_item_t head_item;

	vtg_front #(
		.WINDOW(WINDOW)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_item   (in_item),
		.push_valid(push_valid),
		.push_ready(push_ready),
		.push_item (push_item)
	);

	vtg_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_valid(push_valid),
		.push_ready(push_ready),
		.push_item (push_item),
		.head_valid(head_valid),
		.pop       (pop),
		.head_item (head_item)
	);

	vtg_back #(
		.WINDOW(WINDOW)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_data  (cfg_data),
		.head_valid(head_valid),
		.pop       (pop),
		.head_item (head_item),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item)
	);

endmodule

// File: rtl/vtg_front.sv
module vtg_front
	import vtg_pkg::*;
#(
	parameter int WINDOW = 20
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  in_item_t   in_item,
	output logic       push_valid,
	input  logic       push_ready,
	output work_item_t push_item
);

	localparam logic [16:0] RECIP_T = 17'((2**16 + WINDOW - 1) / WINDOW);
	localparam logic [5:0]  WIN     = 6'(WINDOW);

	logic       v_s1, v_s2;
	logic [1:0] cmd_s1, cmd_s2;
	logic [8:0] temp_s1, temp_s2;
	logic [8:0] tq_s2;

	logic        stall;
	logic [26:0] scale_prod;
	logic [25:0] recip_prod;
	logic [14:0] tq_mul;

	assign stall    = v_s2 && !push_ready;
	assign in_ready = !stall || !v_s1;

	assign scale_prod = in_item.sample * SCALE_MUL;
	assign recip_prod = temp_s1 * RECIP_T;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (in_ready)
				v_s1 <= in_valid;
			if (!stall)
				v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready) begin
			cmd_s1  <= in_item.cmd;
			temp_s1 <= scale_prod[SCALE_SHIFT +: 9];
		end
		if (!stall) begin
			cmd_s2  <= cmd_s1;
			temp_s2 <= temp_s1;
			tq_s2   <= recip_prod[24:16];
		end
	end

	// remainder of the sample against the window length
	assign tq_mul = tq_s2 * WIN;

	always_comb begin
		push_item.cmd  = cmd_s2;
		push_item.temp = temp_s2;
		push_item.tq   = tq_s2;
		push_item.tr   = REM_W'(temp_s2 - tq_mul[8:0]);
	end

	assign push_valid = v_s2;

endmodule

// File: rtl/vtg_queue.sv
module vtg_queue
	import vtg_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push_valid,
	output logic       push_ready,
	input  work_item_t push_item,
	output logic       head_valid,
	input  logic       pop,
	output work_item_t head_item
);

	localparam int PTR_W = $clog2(QUEUE_DEPTH);

	work_item_t         mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q, rd_ptr_q;
	logic [PTR_W:0]     count_q;
	logic               push, pop_ok;

	assign push_ready = count_q != (PTR_W+1)'(QUEUE_DEPTH);
	assign head_valid = count_q != '0;
	assign push       = push_valid && push_ready;
	assign pop_ok     = pop && head_valid;
	assign head_item  = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop_ok)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !pop_ok)
				count_q <= count_q + 1'b1;
			else if (!push && pop_ok)
				count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= push_item;
	end

endmodule

// File: rtl/vtg_back.sv
module vtg_back
	import vtg_pkg::*;
#(
	parameter int WINDOW = 20
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [8:0] cfg_data,
	input  logic       head_valid,
	output logic       pop,
	input  work_item_t head_item,
	output logic       out_valid,
	input  logic       out_ready,
	output out_item_t  out_item
);

	localparam logic [CNT_W-1:0] WIN = CNT_W'(WINDOW);

	logic [8:0]       thresh_q;
	logic             open_q, base_taken_q;
	logic [8:0]       base_temp_q;
	logic [8:0]       win_quo_q;   // window sum kept as quotient and remainder
	logic [REM_W-1:0] win_rem_q;
	logic [CNT_W-1:0] win_cnt_q;
	logic             out_valid_q;
	out_item_t        out_item_q;

	logic             open_d, base_taken_d;
	logic [8:0]       base_temp_d, win_quo_d;
	logic [REM_W-1:0] win_rem_d;
	logic [CNT_W-1:0] win_cnt_d;
	out_item_t        res;

	logic [REM_W:0]   rem_sum;
	logic             carry;
	logic [9:0]       quo_sum;
	logic [CNT_W-1:0] cnt_inc;
	logic [8:0]       avg, diff;

	assign pop = head_valid && (!out_valid_q || out_ready);

	assign rem_sum = {1'b0, win_rem_q} + {1'b0, head_item.tr};
	assign carry   = rem_sum >= (REM_W+1)'(WINDOW);
	assign quo_sum = {1'b0, win_quo_q} + {1'b0, head_item.tq} + {9'd0, carry};
	assign cnt_inc = win_cnt_q + 1'b1;
	assign avg     = quo_sum[8:0];
	assign diff    = (avg >= base_temp_q) ? avg - base_temp_q : base_temp_q - avg;

	always_comb begin
		open_d       = open_q;
		base_taken_d = base_taken_q;
		base_temp_d  = base_temp_q;
		win_quo_d    = win_quo_q;
		win_rem_d    = win_rem_q;
		win_cnt_d    = win_cnt_q;
		res          = '0;
		res.event_res = EV_NONE;
		unique case (head_item.cmd)
			CMD_SAMPLE: begin
				res.sample_temp = head_item.temp;
				if (open_q) begin
					win_quo_d = avg;
					win_rem_d = carry ? REM_W'(rem_sum - (REM_W+1)'(WINDOW))
					                  : rem_sum[REM_W-1:0];
					win_cnt_d = cnt_inc;
					if (cnt_inc >= WIN) begin
						res.average_valid = 1'b1;
						res.average_temp  = avg;
						win_quo_d = '0;
						win_rem_d = '0;
						win_cnt_d = '0;
						if (!base_taken_q) begin
							base_taken_d = 1'b1;
							base_temp_d  = avg;
							res.average_is_baseline = 1'b1;
						end else if (diff > thresh_q) begin
							open_d        = 1'b0;
							base_taken_d  = 1'b0;
							res.event_res = EV_CLOSED_TRIP;
						end
					end
				end
			end
			CMD_OPEN: begin
				if (!open_q) begin
					open_d        = 1'b1;
					base_taken_d  = 1'b0;
					win_quo_d     = '0;
					win_rem_d     = '0;
					win_cnt_d     = '0;
					res.event_res = EV_OPENED;
				end else begin
					res.event_res = EV_REJECTED;
				end
			end
			CMD_CLOSE: begin
				if (open_q) begin
					open_d        = 1'b0;
					base_taken_d  = 1'b0;
					win_quo_d     = '0;
					win_rem_d     = '0;
					win_cnt_d     = '0;
					res.event_res = EV_CLOSED_CMD;
				end else begin
					res.event_res = EV_REJECTED;
				end
			end
			CMD_BAD: begin
				res.event_res = EV_REJECTED;
			end
		endcase
		res.valve_open = open_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thresh_q     <= THRESH_RESET;
			open_q       <= 1'b0;
			base_taken_q <= 1'b0;
			base_temp_q  <= '0;
			win_quo_q    <= '0;
			win_rem_q    <= '0;
			win_cnt_q    <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_we)
				thresh_q <= cfg_data;
			if (pop) begin
				open_q       <= open_d;
				base_taken_q <= base_taken_d;
				base_temp_q  <= base_temp_d;
				win_quo_q    <= win_quo_d;
				win_rem_q    <= win_rem_d;
				win_cnt_q    <= win_cnt_d;
				out_valid_q  <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop)
			out_item_q <= res;
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;

endmodule
